// File: design/qst_pkg.sv
// ----------------------------------------------------------------------------
// qst_pkg
// Types and constants shared by the quaternion-to-transform pipeline stages.
// ----------------------------------------------------------------------------
package qst_pkg;

  localparam int QuatW   = 16;   // Q1.15 component
  localparam int TransW  = 32;   // Q16.16 translation
  localparam int ScaleW  = 16;   // unsigned Q8.8 scale
  localparam int ProdW   = 32;   // Q2.30 component product
  localparam int EntryW  = 34;   // Q.30 matrix entry, range [-4, 4]
  localparam int ResW    = 32;   // Q16.16 result
  localparam int ScProdW = EntryW + ScaleW + 1;  // Q.38 scaled entry
  localparam int FracDrop = 22;  // Q.38 -> Q16.16
  localparam int NumEnt  = 9;

  localparam logic signed [EntryW-1:0] QOne = EntryW'(1) <<< 30;

  localparam int InDataW  = 4 * QuatW + 3 * TransW + ScaleW;
  localparam int OutDataW = NumEnt * ResW + 3 * TransW;

  typedef struct packed {
    logic signed [TransW-1:0] tz;
    logic signed [TransW-1:0] ty;
    logic signed [TransW-1:0] tx;
  } trans_t;

  typedef struct packed {
    logic signed [QuatW-1:0]  qz;
    logic signed [QuatW-1:0]  qy;
    logic signed [QuatW-1:0]  qx;
    logic signed [QuatW-1:0]  qw;
    trans_t                   trans;
    logic        [ScaleW-1:0] scale;
  } in_item_t;

  typedef struct packed {
    logic signed [ProdW-1:0] xx;
    logic signed [ProdW-1:0] yy;
    logic signed [ProdW-1:0] zz;
    logic signed [ProdW-1:0] xy;
    logic signed [ProdW-1:0] xz;
    logic signed [ProdW-1:0] yz;
    logic signed [ProdW-1:0] wx;
    logic signed [ProdW-1:0] wy;
    logic signed [ProdW-1:0] wz;
    trans_t                  trans;
    logic       [ScaleW-1:0] scale;
  } prod_item_t;

  typedef struct packed {
    logic [NumEnt-1:0][EntryW-1:0] ent;
    trans_t                        trans;
    logic [ScaleW-1:0]             scale;
  } ent_item_t;

  typedef struct packed {
    logic [NumEnt-1:0][ResW-1:0] res;
    trans_t                      trans;
  } out_item_t;

  // handshake between neighboring stages
  typedef struct packed {
    logic valid;
  } stg_fwd_t;

  typedef struct packed {
    logic ready;
  } stg_bwd_t;

endpackage

// File: design/qst_products.sv
// ----------------------------------------------------------------------------
// qst_products
// Stage 1: the nine pairwise quaternion products, exact in Q2.30.
// ----------------------------------------------------------------------------
module qst_products import qst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  stg_fwd_t   up_fwd_i,
  output stg_bwd_t   up_bwd_o,
  input  in_item_t   item_i,
  output stg_fwd_t   dn_fwd_o,
  input  stg_bwd_t   dn_bwd_i,
  output prod_item_t item_o
);

  logic       valid_q;
  logic       adv;
  prod_item_t item_d, item_q;

  assign adv = !valid_q || dn_bwd_i.ready;

  always_comb begin
    item_d.xx    = item_i.qx * item_i.qx;
    item_d.yy    = item_i.qy * item_i.qy;
    item_d.zz    = item_i.qz * item_i.qz;
    item_d.xy    = item_i.qx * item_i.qy;
    item_d.xz    = item_i.qx * item_i.qz;
    item_d.yz    = item_i.qy * item_i.qz;
    item_d.wx    = item_i.qw * item_i.qx;
    item_d.wy    = item_i.qw * item_i.qy;
    item_d.wz    = item_i.qw * item_i.qz;
    item_d.trans = item_i.trans;
    item_d.scale = item_i.scale;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= up_fwd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && up_fwd_i.valid) begin
      item_q <= item_d;
    end
  end

  assign up_bwd_o.ready = adv;
  assign dn_fwd_o.valid = valid_q;
  assign item_o         = item_q;

endmodule

// File: design/qst_entries.sv
// ----------------------------------------------------------------------------
// qst_entries
// Stage 2: rotation matrix entries in Q.30, middle column optionally negated.
// ----------------------------------------------------------------------------
module qst_entries import qst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       negate_i,
  input  stg_fwd_t   up_fwd_i,
  output stg_bwd_t   up_bwd_o,
  input  prod_item_t item_i,
  output stg_fwd_t   dn_fwd_o,
  input  stg_bwd_t   dn_bwd_i,
  output ent_item_t  item_o
);

  logic      valid_q;
  logic      adv;
  ent_item_t item_d, item_q;

  logic signed [EntryW-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic signed [EntryW-1:0] s_yz, s_xz, s_xy;

  assign adv = !valid_q || dn_bwd_i.ready;

  assign xx = EntryW'(item_i.xx);
  assign yy = EntryW'(item_i.yy);
  assign zz = EntryW'(item_i.zz);
  assign xy = EntryW'(item_i.xy);
  assign xz = EntryW'(item_i.xz);
  assign yz = EntryW'(item_i.yz);
  assign wx = EntryW'(item_i.wx);
  assign wy = EntryW'(item_i.wy);
  assign wz = EntryW'(item_i.wz);

  assign s_yz = yy + zz;
  assign s_xz = xx + zz;
  assign s_xy = xx + yy;

  // negation folded into operand order where possible; ent[7] negates its sum
  always_comb begin
    item_d.ent[0] = QOne - (s_yz <<< 1);
    item_d.ent[2] = (xz + wy) <<< 1;
    item_d.ent[3] = (xy + wz) <<< 1;
    item_d.ent[5] = (yz - wx) <<< 1;
    item_d.ent[6] = (xz - wy) <<< 1;
    item_d.ent[8] = QOne - (s_xy <<< 1);
    if (negate_i) begin
      item_d.ent[1] = (wz - xy) <<< 1;
      item_d.ent[4] = (s_xz <<< 1) - QOne;
      item_d.ent[7] = (-(yz + wx)) <<< 1;
    end else begin
      item_d.ent[1] = (xy - wz) <<< 1;
      item_d.ent[4] = QOne - (s_xz <<< 1);
      item_d.ent[7] = (yz + wx) <<< 1;
    end
    item_d.trans = item_i.trans;
    item_d.scale = item_i.scale;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= up_fwd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && up_fwd_i.valid) begin
      item_q <= item_d;
    end
  end

  assign up_bwd_o.ready = adv;
  assign dn_fwd_o.valid = valid_q;
  assign item_o         = item_q;

endmodule

// File: design/qst_scale.sv
// ----------------------------------------------------------------------------
// qst_scale
// Stage 3: entries times scale, floor to Q16.16; doubles as output register.
// ----------------------------------------------------------------------------
module qst_scale import qst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  stg_fwd_t  up_fwd_i,
  output stg_bwd_t  up_bwd_o,
  input  ent_item_t item_i,
  output stg_fwd_t  dn_fwd_o,
  input  stg_bwd_t  dn_bwd_i,
  output out_item_t item_o
);

  logic      valid_q;
  logic      adv;
  out_item_t item_d, item_q;

  logic signed [ScaleW:0]  scale_s;
  logic signed [ScProdW-1:0] prod [NumEnt];

  assign adv     = !valid_q || dn_bwd_i.ready;
  assign scale_s = signed'({1'b0, item_i.scale});

  always_comb begin
    for (int k = 0; k < NumEnt; k++) begin
      prod[k] = signed'(item_i.ent[k]) * scale_s;
      // dropping low bits of a two's complement value is a floor
      item_d.res[k] = ResW'(signed'(prod[k][ScProdW-1:FracDrop]));
    end
    item_d.trans = item_i.trans;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= up_fwd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && up_fwd_i.valid) begin
      item_q <= item_d;
    end
  end

  assign up_bwd_o.ready = adv;
  assign dn_fwd_o.valid = valid_q;
  assign item_o         = item_q;

endmodule

// File: design/quaternion_to_scaled_transform.sv
// ----------------------------------------------------------------------------
// quaternion_to_scaled_transform
// Quaternion, translation and uniform scale to a scaled 3x4 affine transform.
//
//   channel  direction  width  payload
//   s_axis   in         176    quat_w,x,y,z, trans_x,y,z, scale_factor
//   m_axis   out        384    row0_col0 .. row2_col2, out_trans_x,y,z
//   cfg      in         1      negate_middle_column (reset 1)
//
// Three register stages: products, matrix entries, scaled result. The last
// one is the output register. One request is taken per cycle unless a
// stall has filled the stages. Each stage holds its request while the next
// one is full and stalled; empty stages ahead still fill. Reset empties
// the pipeline and sets negate_middle_column. Config is taken in any cycle.
// ----------------------------------------------------------------------------
module quaternion_to_scaled_transform import qst_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // cfg
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [0:0]          cfg_data_i,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // quat_w, quat_x, quat_y, quat_z, trans_x, trans_y, trans_z, scale_factor
  input  logic [InDataW-1:0]  s_axis_tdata,
  // output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // row0_col0, row0_col1, row0_col2, row1_col0, ..., row2_col2,
  // out_trans_x, out_trans_y, out_trans_z
  output logic [OutDataW-1:0] m_axis_tdata
);

  logic negate_q;

  in_item_t   in_item;
  prod_item_t prod_item;
  ent_item_t  ent_item;
  out_item_t  out_item;

  stg_fwd_t in_fwd, p_fwd, e_fwd, o_fwd;
  stg_bwd_t in_bwd, p_bwd, e_bwd, o_bwd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      negate_q <= 1'b1;
    end else if (cfg_valid_i) begin
      negate_q <= cfg_data_i[0];
    end
  end

  assign in_item.qw       = s_axis_tdata[15:0];
  assign in_item.qx       = s_axis_tdata[31:16];
  assign in_item.qy       = s_axis_tdata[47:32];
  assign in_item.qz       = s_axis_tdata[63:48];
  assign in_item.trans.tx = s_axis_tdata[95:64];
  assign in_item.trans.ty = s_axis_tdata[127:96];
  assign in_item.trans.tz = s_axis_tdata[159:128];
  assign in_item.scale    = s_axis_tdata[175:160];

  assign in_fwd.valid  = s_axis_tvalid;
  assign s_axis_tready = in_bwd.ready;

  qst_products u_products (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .up_fwd_i (in_fwd),
    .up_bwd_o (in_bwd),
    .item_i   (in_item),
    .dn_fwd_o (p_fwd),
    .dn_bwd_i (p_bwd),
    .item_o   (prod_item)
  );

  qst_entries u_entries (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .negate_i (negate_q),
    .up_fwd_i (p_fwd),
    .up_bwd_o (p_bwd),
    .item_i   (prod_item),
    .dn_fwd_o (e_fwd),
    .dn_bwd_i (e_bwd),
    .item_o   (ent_item)
  );

  qst_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .up_fwd_i (e_fwd),
    .up_bwd_o (e_bwd),
    .item_i   (ent_item),
    .dn_fwd_o (o_fwd),
    .dn_bwd_i (o_bwd),
    .item_o   (out_item)
  );

  assign m_axis_tvalid = o_fwd.valid;
  assign o_bwd.ready   = m_axis_tready;
  assign m_axis_tdata  = {out_item.trans.tz, out_item.trans.ty, out_item.trans.tx,
                          out_item.res};

  // accepted request lands in the product stage
  a_in_to_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> p_fwd.valid)
    else $error("accepted request did not enter product stage");

  // a request parked in the entry stage behind a stalled output stays put
  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_fwd.valid && m_axis_tvalid && !m_axis_tready |=> e_fwd.valid)
    else $error("entry stage lost a request during stall");

  // output drains with nothing behind it: no result appears from nowhere
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !e_fwd.valid |=> !m_axis_tvalid)
    else $error("result produced without a request");

  // a full pipeline stalled at the output takes no new request
  a_full_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_fwd.valid && e_fwd.valid && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("request accepted into a full stalled pipeline");

endmodule
